// ===== src/subtree_parcel_swap_defines.svh =====
// assertion macros for the checker file sps_chk.sv
`ifndef SUBTREE_PARCEL_SWAP_DEFINES_SVH
`define SUBTREE_PARCEL_SWAP_DEFINES_SVH

// concurrent check on clk_i, held off while rst_ni is low
`define SPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent check on clk_i that also runs through reset
`define SPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/sps_pkg.sv =====
// shared widths, codes and controller/datapath command types
package sps_pkg;

  localparam int FUNC_W  = 1;
  localparam int LVL_W   = 4;
  localparam int TREE_W  = 8;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 9;
  localparam int ENTRY_W = 10;
  localparam int CFG_W   = 4;

  localparam logic [FUNC_W-1:0] FUNC_SWAP = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_READ = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // smallest legal tree depth
  localparam logic [CFG_W-1:0] LVL_MIN = 4'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic clr_wr;
    logic rd_en;
    logic rd_entry;
    logic wr_a;
    logic wr_b;
    logic out_load;
  } sps_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic in_err;
    logic in_read;
    logic last_elem;
  } sps_stat_t;

endpackage

// ===== src/sps_if.sv =====
// valid/ready channel interfaces for config, request and result words
interface sps_cfg_if;
  import sps_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] levels_in_use;

  modport source (output valid, output levels_in_use, input ready);
  modport sink   (input valid, input levels_in_use, output ready);
endinterface

interface sps_in_if;
  import sps_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [LVL_W-1:0]  level;
  logic [TREE_W-1:0] tree_index;
  logic              q_choice;
  logic              r_choice;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, output func, output level, output tree_index,
                  output q_choice, output r_choice, output read_index, input ready);
  modport sink   (input valid, input func, input level, input tree_index,
                  input q_choice, input r_choice, input read_index, output ready);
endinterface

interface sps_out_if;
  import sps_pkg::*;
  logic               valid;
  logic               ready;
  logic               status;
  logic [IDX_W-1:0]   q_start;
  logic [IDX_W-1:0]   r_start;
  logic [CNT_W-1:0]   swap_count;
  logic [ENTRY_W-1:0] entry_value;

  modport source (output valid, output status, output q_start, output r_start,
                  output swap_count, output entry_value, input ready);
  modport sink   (input valid, input status, input q_start, input r_start,
                  input swap_count, input entry_value, output ready);
endinterface

// ===== src/sps_ctrl.sv =====
// sequencing state machine for clear pass, swap loop and result hand-off
module sps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sps_pkg::sps_cmd_t cmd_o,
  input  sps_pkg::sps_stat_t stat_i
);
  import sps_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_WRA   = 7'b0001000,
    ST_WRB   = 7'b0010000,
    ST_RDE   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } sps_state_e;

  sps_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.in_err) begin
            state_d = ST_DONE;
          end else if (stat_i.in_read) begin
            state_d = ST_RDE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WRA;
      end
      ST_WRA: begin
        cmd_o.wr_a = 1'b1;
        state_d    = ST_WRB;
      end
      ST_WRB: begin
        // write back the R side and fetch the next pair
        cmd_o.wr_b  = 1'b1;
        cmd_o.rd_en = 1'b1;
        state_d     = stat_i.last_elem ? ST_DONE : ST_WRA;
      end
      ST_RDE: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_entry = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/sps_dp.sv =====
// datapath: level register, argument decode, address walk, map memory, result register
module sps_dp #(
  parameter int MAX_LEVELS = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sps_pkg::CFG_W-1:0]    cfg_levels_i,
  input  logic [sps_pkg::FUNC_W-1:0]   func_i,
  input  logic [sps_pkg::LVL_W-1:0]    level_i,
  input  logic [sps_pkg::TREE_W-1:0]   tree_index_i,
  input  logic                         q_choice_i,
  input  logic                         r_choice_i,
  input  logic [sps_pkg::IDX_W-1:0]    read_index_i,
  input  sps_pkg::sps_cmd_t            cmd_i,
  output sps_pkg::sps_stat_t           stat_o,
  output logic                         status_o,
  output logic [sps_pkg::IDX_W-1:0]    q_start_o,
  output logic [sps_pkg::IDX_W-1:0]    r_start_o,
  output logic [sps_pkg::CNT_W-1:0]    swap_count_o,
  output logic [sps_pkg::ENTRY_W-1:0]  entry_value_o
);
  import sps_pkg::*;

  localparam int AW      = MAX_LEVELS - 1;
  localparam int DEPTH   = 1 << AW;
  localparam int CW      = AW + TREE_W;
  localparam int LVL_TOP = (MAX_LEVELS > 15) ? 15 : MAX_LEVELS;
  localparam logic [CFG_W-1:0] LvlTop = CFG_W'(LVL_TOP);

  logic [CFG_W-1:0]   lvl_q, lvl_d;
  logic [CFG_W-1:0]   lvl_room, nleaf_sh, shift_s;
  logic [CW-1:0]      idx_w, base_w, qs_w, rs_w, cnt_w, clr_w;
  logic               read_err, swap_err, in_read;

  logic               err_q, read_q;
  logic [IDX_W-1:0]   qs_q, rs_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [AW-1:0]      a_q, b_q, rem_q, ridx_q, clr_q;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]      ra, rb, wa;
  logic [ENTRY_W-1:0] wd;
  logic               we;

  // level register with saturation
  always_comb begin
    lvl_d = cfg_levels_i;
    if (cfg_levels_i < LVL_MIN) begin
      lvl_d = LVL_MIN;
    end else if (cfg_levels_i > LvlTop) begin
      lvl_d = LvlTop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= LvlTop;
    end else if (cfg_we_i) begin
      lvl_q <= lvl_d;
    end
  end

  // argument checks and block geometry
  always_comb begin
    lvl_room = lvl_q - LVL_MIN;
    nleaf_sh = lvl_q - 4'd1;
    shift_s  = lvl_room - level_i;
    idx_w    = CW'(read_index_i);
    read_err = (idx_w >> nleaf_sh) != '0;
    swap_err = (level_i > lvl_room) || ((tree_index_i >> level_i) != '0);
    in_read  = (func_i == FUNC_READ);
    base_w   = (CW'(tree_index_i) << shift_s) << 2;
    qs_w     = base_w + (CW'(q_choice_i) << shift_s);
    rs_w     = base_w + (CW'({1'b1, r_choice_i}) << shift_s);
    cnt_w    = CW'(1) << shift_s;
    clr_w    = CW'(clr_q);
  end

  assign stat_o.in_err    = in_read ? read_err : swap_err;
  assign stat_o.in_read   = in_read;
  assign stat_o.last_elem = (rem_q == AW'(1));
  assign stat_o.clr_last  = &clr_q;

  // item registers and element walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q  <= stat_o.in_err;
      read_q <= in_read;
      qs_q   <= qs_w[IDX_W-1:0];
      rs_q   <= rs_w[IDX_W-1:0];
      cnt_q  <= cnt_w[CNT_W-1:0];
      a_q    <= qs_w[AW-1:0];
      b_q    <= rs_w[AW-1:0];
      rem_q  <= cnt_w[AW-1:0];
      ridx_q <= idx_w[AW-1:0];
    end else if (cmd_i.wr_b) begin
      a_q   <= a_q + AW'(1);
      b_q   <= b_q + AW'(1);
      rem_q <= rem_q - AW'(1);
    end
  end

  // clearing pass address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // memory port addressing
  always_comb begin
    rb = cmd_i.wr_b ? (b_q + AW'(1)) : b_q;
    if (cmd_i.rd_entry) begin
      ra = ridx_q;
    end else begin
      ra = cmd_i.wr_b ? (a_q + AW'(1)) : a_q;
    end
    we = cmd_i.clr_wr || cmd_i.wr_a || cmd_i.wr_b;
    if (cmd_i.clr_wr) begin
      wa = clr_q;
      wd = clr_w[ENTRY_W-1:0];
    end else if (cmd_i.wr_a) begin
      wa = a_q;
      wd = rd_b_q;
    end else begin
      wa = b_q;
      wd = rd_a_q;
    end
  end

  // parcel map: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (cmd_i.rd_en) begin
      rd_a_q <= mem[ra];
      rd_b_q <= mem[rb];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o      <= err_q ? STATUS_ERR : STATUS_OK;
      q_start_o     <= '0;
      r_start_o     <= '0;
      swap_count_o  <= '0;
      entry_value_o <= '0;
      if (!err_q) begin
        if (read_q) begin
          entry_value_o <= rd_a_q;
        end else begin
          q_start_o    <= qs_q;
          r_start_o    <= rs_q;
          swap_count_o <= cnt_q;
        end
      end
    end
  end

endmodule

// ===== src/subtree_parcel_swap.sv =====
// top level of the parcel map subtree swapper
//
//  channel  dir  handshake     word
//  cfg_i    in   valid/ready   levels_in_use (ready always high)
//  in_i     in   valid/ready   func, level, tree_index, q_choice, r_choice, read_index
//  out_o    out  valid/ready   status, q_start, r_start, swap_count, entry_value
//
// swap: 2^s entry pairs, s = levels_in_use-3-level; after accept the controller runs ST_RD,
//   then ST_WRA and ST_WRB per pair, then ST_DONE; the single write port of the map memory
//   writes the Q entry in ST_WRA, the R entry in ST_WRB; read: ST_RDE, ST_DONE; rejected: ST_DONE
// after reset the map is refilled with identity, all 2^(MAX_LEVELS-1) entries
//   (1024 by default), in_i not ready meanwhile; cfg_i writes are taken throughout
// a finished result sits in the output register; the next word is accepted meanwhile
//   and its result waits until that register is taken
module subtree_parcel_swap #(
  parameter int MAX_LEVELS = 11
) (
  input logic        clk_i,
  input logic        rst_ni,
  sps_cfg_if.sink    cfg_i,
  sps_in_if.sink     in_i,
  sps_out_if.source  out_o
);
  import sps_pkg::*;

  sps_cmd_t  cmd;
  sps_stat_t stat;

  // config channel never stalls
  assign cfg_i.ready = 1'b1;

  // controller
  sps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // datapath and map memory
  sps_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_i.valid && cfg_i.ready),
    .cfg_levels_i  (cfg_i.levels_in_use),
    .func_i        (in_i.func),
    .level_i       (in_i.level),
    .tree_index_i  (in_i.tree_index),
    .q_choice_i    (in_i.q_choice),
    .r_choice_i    (in_i.r_choice),
    .read_index_i  (in_i.read_index),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (out_o.status),
    .q_start_o     (out_o.q_start),
    .r_start_o     (out_o.r_start),
    .swap_count_o  (out_o.swap_count),
    .entry_value_o (out_o.entry_value)
  );

endmodule

// ===== src/sps_chk.sv =====
// port-level checker for the subtree swapper and its bind
`include "subtree_parcel_swap_defines.svh"

module sps_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         out_status_i,
  input logic [sps_pkg::IDX_W-1:0]    out_q_start_i,
  input logic [sps_pkg::IDX_W-1:0]    out_r_start_i,
  input logic [sps_pkg::CNT_W-1:0]    out_swap_count_i,
  input logic [sps_pkg::ENTRY_W-1:0]  out_entry_value_i
);
  import sps_pkg::*;

  // a stalled result word holds
  `SPS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_q_start_i) && $stable(out_r_start_i) && $stable(out_swap_count_i) && $stable(out_entry_value_i) && $stable(out_status_i), "stalled result word changed")

  // request not ready when reset is released, as the map refill begins
  `SPS_ASSERT(a_clear_busy, $rose(rst_ni) |-> !in_ready_i, "request ready during clearing pass")

  // one word in flight: ready drops after an accept
  `SPS_ASSERT(a_one_item, in_valid_i && in_ready_i |=> !in_ready_i, "second word taken while busy")

  // a rejected word reports all fields zero
  `SPS_ASSERT(a_err_zero, out_valid_i && (out_status_i == STATUS_ERR) |-> (out_q_start_i == '0) && (out_r_start_i == '0) && (out_swap_count_i == '0) && (out_entry_value_i == '0), "rejected word carries data")

endmodule

bind subtree_parcel_swap sps_chk u_sps_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_status_i      (out_o.status),
  .out_q_start_i     (out_o.q_start),
  .out_r_start_i     (out_o.r_start),
  .out_swap_count_i  (out_o.swap_count),
  .out_entry_value_i (out_o.entry_value)
);

// ===== tb/tb.sv =====
// self-checking bench for subtree_parcel_swap: directed and random words against a shadow map
`timescale 1ns / 100ps

module tb;
  import sps_pkg::*;

  localparam int MAX_LEVELS     = 11;
  localparam int MAP_DEPTH      = 1 << (MAX_LEVELS - 1);
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int TAIL_CYCLES    = 520;

  // one request word and one result word
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [LVL_W-1:0]  level;
    logic [TREE_W-1:0] tree_index;
    logic              q_choice;
    logic              r_choice;
    logic [IDX_W-1:0]  read_index;
  } swap_req_t;

  typedef struct packed {
    logic               status;
    logic [IDX_W-1:0]   q_start;
    logic [IDX_W-1:0]   r_start;
    logic [CNT_W-1:0]   swap_count;
    logic [ENTRY_W-1:0] entry_value;
  } swap_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sps_cfg_if cfg_if ();
  sps_in_if  req_if ();
  sps_out_if res_if ();

  subtree_parcel_swap #(
    .MAX_LEVELS(MAX_LEVELS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (req_if),
    .out_o (res_if)
  );

  // shadow copy of the block state
  logic [ENTRY_W-1:0] shadow_map [MAP_DEPTH];
  int unsigned        shadow_levels;

  swap_res_t pending_results [$];
  int        fail_count = 0;
  bit        idle_en;
  int        hold_reqs;
  int        hold_seen;
  int        hold_left;
  int        stall_left;
  int        quiet_cycles = 0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected result of one word, updates the shadow map
  function automatic swap_res_t predict_parcel_swap(input swap_req_t w);
    swap_res_t          r;
    int unsigned        s, base, qs, rs, n, leaves, k, a, b;
    logic [ENTRY_W-1:0] tmp;
    r = '0;
    r.status = STATUS_OK;
    leaves = 1 << (shadow_levels - 1);
    if (w.func == FUNC_READ) begin
      if (w.read_index >= leaves) begin
        r.status = STATUS_ERR;
      end else begin
        r.entry_value = shadow_map[w.read_index];
      end
    end else if (int'(w.level) > int'(shadow_levels) - 3 ||
                 int'(w.tree_index) >= (1 << w.level)) begin
      r.status = STATUS_ERR;
    end else begin
      s    = shadow_levels - 3 - w.level;
      base = int'(w.tree_index) << (s + 2);
      qs   = (int'(w.q_choice) << s) + base;
      rs   = ((2 + int'(w.r_choice)) << s) + base;
      n    = 1 << s;
      for (k = 0; k < n; k++) begin
        a = (qs + k) & (MAP_DEPTH - 1);
        b = (rs + k) & (MAP_DEPTH - 1);
        tmp           = shadow_map[a];
        shadow_map[a] = shadow_map[b];
        shadow_map[b] = tmp;
      end
      r.q_start    = IDX_W'(qs);
      r.r_start    = IDX_W'(rs);
      r.swap_count = CNT_W'(n);
    end
    return r;
  endfunction

  function automatic swap_req_t mk_word(input logic [FUNC_W-1:0] func, input int level,
                                        input int tree, input bit qc, input bit rc,
                                        input int ridx);
    swap_req_t w;
    w.func       = func;
    w.level      = LVL_W'(level);
    w.tree_index = TREE_W'(tree);
    w.q_choice   = qc;
    w.r_choice   = rc;
    w.read_index = IDX_W'(ridx);
    return w;
  endfunction

  // mostly legal swaps with small blocks and legal reads, some raw noise
  function automatic swap_req_t rand_word();
    swap_req_t   w;
    int unsigned smax, s, pick;
    w.func       = FUNC_W'($urandom_range(0, 1));
    w.level      = LVL_W'($urandom_range(0, 15));
    w.tree_index = TREE_W'($urandom_range(0, 255));
    w.q_choice   = 1'($urandom_range(0, 1));
    w.r_choice   = 1'($urandom_range(0, 1));
    w.read_index = IDX_W'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      smax = shadow_levels - 3;
      if ($urandom_range(0, 9) < 8) begin
        s = $urandom_range(0, (smax < 3) ? smax : 3);
      end else begin
        s = $urandom_range(0, smax);
      end
      w.func       = FUNC_SWAP;
      w.level      = LVL_W'(smax - s);
      w.tree_index = TREE_W'($urandom_range(0, (1 << w.level) - 1));
    end else if (pick < 85) begin
      w.func       = FUNC_READ;
      w.read_index = IDX_W'($urandom_range(0, (1 << (shadow_levels - 1)) - 1));
    end
    return w;
  endfunction

  // offer one word, with an optional gap first
  task automatic send_word(input swap_req_t w);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= w.func;
    req_if.level      <= w.level;
    req_if.tree_index <= w.tree_index;
    req_if.q_choice   <= w.q_choice;
    req_if.r_choice   <= w.r_choice;
    req_if.read_index <= w.read_index;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_results = {pending_results, predict_parcel_swap(w)};
  endtask

  // drop valid and wait for every expected result
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_levels(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_if.valid         <= 1'b1;
    cfg_if.levels_in_use <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    if (v < LVL_MIN) begin
      shadow_levels = 32'(LVL_MIN);
    end else if (v > MAX_LEVELS) begin
      shadow_levels = MAX_LEVELS;
    end else begin
      shadow_levels = 32'(v);
    end
  endtask

  task automatic send_random(input int count);
    int i;
    for (i = 0; i < count; i++) send_word(rand_word());
  endtask

  // identity map after reset at full depth
  task automatic test_reset_identity();
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 0));
    send_word(mk_word(FUNC_READ, 15, 255, 1, 1, 1023));
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 512));
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 1));
  endtask

  // largest and smallest blocks, then read back
  task automatic test_swap_extremes();
    send_word(mk_word(FUNC_SWAP, 0, 0, 1, 1, 1023));
    send_word(mk_word(FUNC_SWAP, 8, 255, 0, 1, 0));
    send_word(mk_word(FUNC_SWAP, 0, 0, 0, 0, 0));
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 256));
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 0));
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 1020));
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 1022));
  endtask

  // bad level, bad node, bad read index
  task automatic test_out_of_range();
    send_word(mk_word(FUNC_SWAP, 9, 0, 0, 0, 0));
    send_word(mk_word(FUNC_SWAP, 15, 255, 1, 1, 0));
    send_word(mk_word(FUNC_SWAP, 2, 4, 1, 0, 0));
    write_levels(4'd3);
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 4));
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 3));
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 1023));
    send_word(mk_word(FUNC_SWAP, 0, 0, 1, 0, 0));
    send_word(mk_word(FUNC_SWAP, 1, 0, 0, 0, 0));
    send_word(mk_word(FUNC_SWAP, 0, 1, 0, 0, 0));
  endtask

  // saturating writes, map beyond the size is kept
  task automatic test_level_change();
    write_levels(4'd0);
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 0));
    write_levels(4'd15);
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 1023));
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 257));
    write_levels(4'd12);
    send_word(mk_word(FUNC_READ, 0, 0, 0, 0, 768));
  endtask

  // random words over a range of tree depths
  task automatic test_random_levels();
    logic [CFG_W-1:0] depth_list [10];
    int               j;
    depth_list = '{4'd11, 4'd7, 4'd3, 4'd9, 4'd5, 4'd4, 4'd10, 4'd6, 4'd8, 4'd11};
    for (j = 0; j < 10; j++) begin
      write_levels(depth_list[j]);
      send_random(80);
    end
  endtask

  // receiver holds off while words keep coming
  task automatic test_backpressure();
    write_levels(4'd6);
    idle_en = 1'b0;
    hold_reqs++;
    send_random(60);
    idle_en = 1'b1;
    wait_drained();
  endtask

  // full rate on both sides
  task automatic test_no_idle();
    write_levels(4'd8);
    idle_en = 1'b0;
    send_random(200);
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  endtask

  // result ready: long hold-offs on request, else random stall bursts
  initial begin : res_ready_drive
    hold_seen  = 0;
    hold_left  = 0;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_seen != hold_reqs) begin
        hold_seen++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    swap_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, res_if.status);
          fail_count++;
        end
        if (res_if.q_start !== want.q_start) begin
          $error("q_start: expected %0d, actual %0d", want.q_start, res_if.q_start);
          fail_count++;
        end
        if (res_if.r_start !== want.r_start) begin
          $error("r_start: expected %0d, actual %0d", want.r_start, res_if.r_start);
          fail_count++;
        end
        if (res_if.swap_count !== want.swap_count) begin
          $error("swap_count: expected %0d, actual %0d", want.swap_count,
                 res_if.swap_count);
          fail_count++;
        end
        if (res_if.entry_value !== want.entry_value) begin
          $error("entry_value: expected %0d, actual %0d", want.entry_value,
                 res_if.entry_value);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, then the tests in turn
  initial begin : main_seq
    int i;
    hold_reqs     = 0;
    idle_en       = 1'b1;
    shadow_levels = MAX_LEVELS;
    for (i = 0; i < MAP_DEPTH; i++) shadow_map[i] = ENTRY_W'(i);
    rst_ni               <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.levels_in_use <= '0;
    req_if.valid         <= 1'b0;
    req_if.func          <= FUNC_SWAP;
    req_if.level         <= '0;
    req_if.tree_index    <= '0;
    req_if.q_choice      <= 1'b0;
    req_if.r_choice      <= 1'b0;
    req_if.read_index    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_identity();
    test_swap_extremes();
    test_out_of_range();
    test_level_change();
    test_random_levels();
    test_backpressure();
    test_no_idle();
    finish_run();
  end

endmodule
